// ===== design/hafc_pkg.sv =====
// shared constants, types and functions of the hex ascii frame crc checker
// no dependencies
`timescale 1ns / 1ps
package hafc_pkg;

    localparam int          MAX_PAYLOAD_DEF = 32;
    localparam logic [15:0] CRC_INIT        = 16'hFFFF;
    localparam logic [15:0] CRC_POLY        = 16'h1021;
    localparam logic [6:0]  POS_MAX         = 7'd127;
    localparam logic [3:0]  HDR_RESET       = 4'd6;
    localparam logic [5:0]  LEN_RESET       = 6'd27;
    localparam logic [7:0]  DIGIT_NINE      = 8'd57;
    localparam logic [7:0]  ALPHA_OFFSET    = 8'd55;
    localparam logic [7:0]  NUM_OFFSET      = 8'd48;

    // configuration register indexes
    localparam logic CFG_HEADER_CHARS = 1'b0;
    localparam logic CFG_PAYLOAD_LEN  = 1'b1;

    // frame end request from the parser to the drain sequencer
    typedef struct packed {
        logic       start;
        logic       ok;
        logic [5:0] last_idx;
    } hafc_req_t;

    function automatic logic [7:0] digit_value(input logic [7:0] c);
        return (c > DIGIT_NINE) ? c - ALPHA_OFFSET : c - NUM_OFFSET;
    endfunction

    // crc-16/ccitt-false, msb first, one byte
    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
        logic [15:0] crc;
        crc = crc_in ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            if (crc[15]) begin
                crc = {crc[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                crc = {crc[14:0], 1'b0};
            end
        end
        return crc;
    endfunction

endpackage

// ===== design/hafc_store.sv =====
// payload byte memory, one write port and one registered read port
// no dependencies
`timescale 1ns / 1ps
module hafc_store #(
    parameter int DEPTH  = 32,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [7:0]        wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [7:0]        rd_data
);

    logic [7:0] mem [DEPTH];
    logic [7:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== design/hafc_parser.sv =====
// per character frame parser: header skip, hex pairing, crc and store writes
// depends on hafc_pkg
`timescale 1ns / 1ps
module hafc_parser
    import hafc_pkg::*;
#(
    parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF,
    parameter int ADDR_W      = $clog2(MAX_PAYLOAD)
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              accept,
    input  logic [7:0]        rx_char,
    input  logic              frame_start,
    input  logic [3:0]        header_chars,
    input  logic [5:0]        payload_len,
    output logic              wr_en,
    output logic [ADDR_W-1:0] wr_addr,
    output logic [7:0]        wr_data,
    output hafc_req_t         req
);

    logic [6:0]  pos_reg, pos_next, pos_e;
    logic [3:0]  hi_reg, hi_next, hi_e;
    logic [15:0] crc_reg, crc_next, crc_e;
    logic [7:0]  rcv_reg, rcv_next, rcv_e;
    logic        drop_reg, drop_next, drop_e;

    logic [6:0]  len7, rel;
    logic [5:0]  byte_no;
    logic [7:0]  dval, byte_val;
    logic [15:0] rcv_full;

    always_comb begin
        // clamp the length into 1 .. MAX_PAYLOAD
        if (payload_len == 6'd0) begin
            len7 = 7'd1;
        end else if ({1'b0, payload_len} > 7'(MAX_PAYLOAD)) begin
            len7 = 7'(MAX_PAYLOAD);
        end else begin
            len7 = {1'b0, payload_len};
        end

        pos_e  = frame_start ? 7'd0 : pos_reg;
        hi_e   = frame_start ? 4'd0 : hi_reg;
        crc_e  = frame_start ? CRC_INIT : crc_reg;
        rcv_e  = frame_start ? 8'd0 : rcv_reg;
        drop_e = frame_start ? 1'b0 : drop_reg;

        rel      = pos_e - {3'b000, header_chars};
        byte_no  = rel[6:1];
        dval     = digit_value(rx_char);
        byte_val = {hi_e, 4'h0} + dval;
        rcv_full = {rcv_e, byte_val};

        pos_next  = pos_e;
        hi_next   = hi_e;
        crc_next  = crc_e;
        rcv_next  = rcv_e;
        drop_next = drop_e;
        wr_en     = 1'b0;
        wr_addr   = byte_no[ADDR_W-1:0];
        wr_data   = byte_val;
        req.start    = 1'b0;
        req.ok       = (rcv_full == crc_e);
        req.last_idx = 6'(len7 - 7'd1);

        if (!drop_e) begin
            if (pos_e < POS_MAX) begin
                pos_next = pos_e + 7'd1;
            end
            if (pos_e == 7'd0 && rx_char == 8'd0) begin
                drop_next = 1'b1;
            end else if (pos_e >= {3'b000, header_chars} && pos_e < POS_MAX &&
                         {1'b0, byte_no} <= len7 + 7'd1) begin
                if (!rel[0]) begin
                    hi_next = dval[3:0];
                end else if ({1'b0, byte_no} < len7) begin
                    wr_en    = accept;
                    crc_next = crc_byte(crc_e, byte_val);
                end else if ({1'b0, byte_no} == len7) begin
                    rcv_next = byte_val;
                end else begin
                    req.start = accept;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg  <= '0;
            hi_reg   <= '0;
            crc_reg  <= CRC_INIT;
            rcv_reg  <= '0;
            drop_reg <= 1'b0;
        end else if (accept) begin
            pos_reg  <= pos_next;
            hi_reg   <= hi_next;
            crc_reg  <= crc_next;
            rcv_reg  <= rcv_next;
            drop_reg <= drop_next;
        end
    end

endmodule

// ===== design/hafc_drain.sv =====
// result sequencer: reads the stored payload back and fills the output register
// depends on hafc_pkg
`timescale 1ns / 1ps
module hafc_drain
    import hafc_pkg::*;
#(
    parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF,
    parameter int ADDR_W      = $clog2(MAX_PAYLOAD)
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  hafc_req_t         req,
    output logic              idle,
    output logic              rd_en,
    output logic [ADDR_W-1:0] rd_addr,
    input  logic [7:0]        rd_data,
    output logic              m_valid,
    input  logic              m_ready,
    output logic              m_crc_ok,
    output logic [7:0]        m_data_byte,
    output logic [4:0]        m_byte_index,
    output logic              m_last
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FETCH,
        ST_PUT
    } state_t;

    state_t            state_reg;
    logic [ADDR_W-1:0] cnt_reg, last_reg;
    logic              ok_reg;
    logic              m_valid_reg, m_crc_ok_reg, m_last_reg;
    logic [7:0]        m_data_reg;
    logic [4:0]        m_idx_reg;
    logic              final_beat;
    logic              put_fire;

    assign final_beat = !ok_reg || (cnt_reg == last_reg);

    // output register is loaded when it is empty or being emptied
    assign put_fire = (state_reg == ST_PUT) && (!m_valid_reg || m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            last_reg    <= '0;
            ok_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (m_valid_reg && m_ready && !put_fire) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (req.start) begin
                        ok_reg    <= req.ok;
                        last_reg  <= ADDR_W'(req.last_idx);
                        cnt_reg   <= '0;
                        state_reg <= req.ok ? ST_FETCH : ST_PUT;
                    end
                end
                ST_FETCH: begin
                    state_reg <= ST_PUT;
                end
                ST_PUT: begin
                    if (put_fire) begin
                        m_valid_reg  <= 1'b1;
                        m_crc_ok_reg <= ok_reg;
                        m_data_reg   <= ok_reg ? rd_data : 8'd0;
                        m_idx_reg    <= ok_reg ? 5'(cnt_reg) : 5'd0;
                        m_last_reg   <= final_beat;
                        if (final_beat) begin
                            state_reg <= ST_IDLE;
                        end else begin
                            cnt_reg   <= cnt_reg + ADDR_W'(1);
                            state_reg <= ST_FETCH;
                        end
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign idle         = (state_reg == ST_IDLE);
    assign rd_en        = (state_reg == ST_FETCH);
    assign rd_addr      = cnt_reg;
    assign m_valid      = m_valid_reg;
    assign m_crc_ok     = m_crc_ok_reg;
    assign m_data_byte  = m_data_reg;
    assign m_byte_index = m_idx_reg;
    assign m_last       = m_last_reg;

endmodule

// ===== design/hex_ascii_frame_crc_checker_unit.sv =====
// hex ascii frame checker with crc-16/ccitt-false, top level
// a good frame's first result is registered through the store read (ST_FETCH) and then
// the output register (ST_PUT) after its last character beat; a failure beat skips ST_FETCH
// one character per cycle while s_ready is high; a result is fetched only after the previous one is put
// input is held off while the payload of a good frame or a failure beat is drained
// reset (aresetn, synchronous, active low) clears control state and loads register defaults
`timescale 1ns / 1ps
module hex_ascii_frame_crc_checker_unit
    import hafc_pkg::*;
#(
    parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    // configuration write port
    input  logic       cfg_wr_en,
    input  logic       cfg_index,
    input  logic [5:0] cfg_wdata,
    // character input channel
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_rx_char,
    input  logic       s_frame_start,
    // result channel
    output logic       m_valid,
    input  logic       m_ready,
    output logic       m_crc_ok,
    output logic [7:0] m_data_byte,
    output logic [4:0] m_byte_index,
    output logic       m_last
);

    localparam int ADDR_W = $clog2(MAX_PAYLOAD);

    logic [3:0]        hdr_reg;
    logic [5:0]        len_reg;
    logic              accept;
    logic              wr_en, rd_en, drain_idle;
    logic [ADDR_W-1:0] wr_addr, rd_addr;
    logic [7:0]        wr_data, rd_data;
    hafc_req_t         req;

    // configuration registers, to be written only while the block is idle; the block itself does not enforce it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hdr_reg <= HDR_RESET;
            len_reg <= LEN_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_HEADER_CHARS: hdr_reg <= cfg_wdata[3:0];
                CFG_PAYLOAD_LEN:  len_reg <= cfg_wdata;
                default:          hdr_reg <= hdr_reg;
            endcase
        end
    end

    // characters are taken only while no drain is running, so the store
    // never sees a write to an entry that is being read back
    assign s_ready = drain_idle;
    assign accept  = s_valid && s_ready;

    hafc_parser #(
        .MAX_PAYLOAD (MAX_PAYLOAD),
        .ADDR_W      (ADDR_W)
    ) u_parser (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .accept       (accept),
        .rx_char      (s_rx_char),
        .frame_start  (s_frame_start),
        .header_chars (hdr_reg),
        .payload_len  (len_reg),
        .wr_en        (wr_en),
        .wr_addr      (wr_addr),
        .wr_data      (wr_data),
        .req          (req)
    );

    // payload store, one entry per data byte
    hafc_store #(
        .DEPTH  (MAX_PAYLOAD),
        .ADDR_W (ADDR_W)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // drain: fetch an entry, then put it into the output register once free; a failure beat skips the fetch
    hafc_drain #(
        .MAX_PAYLOAD (MAX_PAYLOAD),
        .ADDR_W      (ADDR_W)
    ) u_drain (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .req          (req),
        .idle         (drain_idle),
        .rd_en        (rd_en),
        .rd_addr      (rd_addr),
        .rd_data      (rd_data),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_crc_ok     (m_crc_ok),
        .m_data_byte  (m_data_byte),
        .m_byte_index (m_byte_index),
        .m_last       (m_last)
    );

    // store writes only come from accepted characters
    assert property (@(posedge aclk) disable iff (!aresetn) wr_en |-> accept)
        else $error("store write without an accepted character");

    // a frame end request is only raised while the drain is idle
    assert property (@(posedge aclk) disable iff (!aresetn) req.start |-> drain_idle)
        else $error("frame end while drain busy");

    // a failure beat is a lone final beat with zeroed payload
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_crc_ok) |-> (m_last && m_data_byte == 8'd0 && m_byte_index == 5'd0))
        else $error("malformed failure beat");

    // after a frame end the input stays blocked on the next cycle
    assert property (@(posedge aclk) disable iff (!aresetn) req.start |=> !s_ready)
        else $error("input not held off during drain");

endmodule
